/* hdl/thrp_pkg.sv */
// ----------------------------------------------------------------------------
// thrp_pkg: shared types and constants for the texture handle recycling pool
// Item structs, operation and outcome codes, pool entry layout, FSM states.
// ----------------------------------------------------------------------------
package thrp_pkg;

  localparam int POOL_DEPTH  = 64;
  localparam int IDX_W       = $clog2(POOL_DEPTH);
  localparam int CNT_W       = $clog2(POOL_DEPTH + 1);
  localparam int COUNT_OUT_W = 7;
  localparam int LIMIT_W     = 27;
  localparam int AREA_W      = 26;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_NONE    = 2'd3
  } thrp_op_t;

  typedef enum logic [2:0] {
    OC_EXACT   = 3'd0,
    OC_MIP     = 3'd1,
    OC_FRESH   = 3'd2,
    OC_RELEASE = 3'd3,
    OC_CLEAR   = 3'd4,
    OC_DROP    = 3'd5
  } thrp_outcome_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [12:0] width;
    logic [12:0] height;
    logic [4:0]  mip_levels;
    logic        render_target;
    logic [31:0] handle_in;
  } thrp_in_t;

  typedef struct packed {
    logic [31:0]            handle_out;
    logic [2:0]             outcome;
    logic                   shrunk;
    logic [COUNT_OUT_W-1:0] pool_count;
  } thrp_out_t;

  typedef struct packed {
    logic        render_target;
    logic [4:0]  mip_levels;
    logic [12:0] height;
    logic [12:0] width;
    logic [31:0] handle;
  } thrp_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_REL,
    ST_OUT
  } thrp_state_t;

endpackage

/* hdl/texture_handle_recycling_pool_top.sv */
// ----------------------------------------------------------------------------
// texture_handle_recycling_pool_top: recycled texture handle pool
// Allocate: entries are read newest-first through the single memory read
//   port (none for an empty pool, else 1..count), then the younger entries
//   are moved down one place after removal. Release writes the entry in its
//   own state; clear empties the pool at acceptance.
// The input stalls until the result moves into the output register, so the
//   next item can be accepted from the cycle the result appears, later when the
//   output is stalled. A result that still waits does not block the next item.
// Synchronous reset empties the pool and sets the fresh counter to one; the
//   entry memory itself is not cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module texture_handle_recycling_pool_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  thrp_pkg::thrp_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output thrp_pkg::thrp_out_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [thrp_pkg::LIMIT_W-1:0]         cfg_wr_data
);
  import thrp_pkg::*;

  // Control state.
  thrp_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [31:0]         fresh_r, fresh_nxt;
  logic [LIMIT_W-1:0]  limit_r;
  logic                out_valid_r, out_valid_nxt;

  // Working registers of the item in flight.
  thrp_in_t            item_r, item_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]    src_r, src_nxt;
  logic                mip_hit_r, mip_hit_nxt;
  logic [IDX_W-1:0]    mip_idx_r, mip_idx_nxt;
  logic [31:0]         mip_handle_r, mip_handle_nxt;
  thrp_out_t           res_r, res_nxt;
  thrp_out_t           out_data_r, out_data_nxt;

  // Entry memory: one write port, one registered read port.
  thrp_entry_t         mem [POOL_DEPTH];
  thrp_entry_t         rd_data_r;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  thrp_entry_t         wr_data;

  // Compare and release helpers.
  logic                hit_exact;
  logic                hit_mip;
  logic                take_go;
  logic [IDX_W-1:0]    take_idx;
  logic [31:0]         take_handle;
  logic [2:0]          take_outcome;
  logic [AREA_W-1:0]   area;
  logic                do_shrink;
  logic                in_accept;
  logic                out_free;
  logic [CNT_W-1:0]    count_dec;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign count_dec = count_r - CNT_W'(1);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The entry under test is the one read in the previous cycle.
  assign hit_mip   = (rd_data_r.mip_levels == item_r.mip_levels) &&
                     (rd_data_r.render_target == item_r.render_target);
  assign hit_exact = hit_mip && (rd_data_r.width == item_r.width) &&
                     (rd_data_r.height == item_r.height);

  // A single-mip release larger than the limit is recorded as 1x1.
  assign area      = AREA_W'(item_r.width) * AREA_W'(item_r.height);
  assign do_shrink = ({1'b0, area} > limit_r) && (item_r.mip_levels == 5'd1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fresh_nxt      = fresh_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    item_nxt       = item_r;
    chk_idx_nxt    = chk_idx_r;
    src_nxt        = src_r;
    mip_hit_nxt    = mip_hit_r;
    mip_idx_nxt    = mip_idx_r;
    mip_handle_nxt = mip_handle_r;
    res_nxt        = res_r;
    rd_addr        = chk_idx_r;
    wr_en          = 1'b0;
    wr_addr        = src_r - IDX_W'(1);
    wr_data        = rd_data_r;
    take_go        = 1'b0;
    take_idx       = chk_idx_r;
    take_handle    = rd_data_r.handle;
    take_outcome   = OC_EXACT;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          item_nxt    = in_data;
          mip_hit_nxt = 1'b0;
          case (in_data.op)
            OP_ALLOC: begin
              if (count_r == '0) begin
                // Empty pool: a fresh handle right away.
                res_nxt.handle_out = fresh_r;
                res_nxt.outcome    = OC_FRESH;
                res_nxt.shrunk     = 1'b0;
                res_nxt.pool_count = COUNT_OUT_W'(count_r);
                fresh_nxt = (fresh_r == '1) ? 32'd1 : fresh_r + 32'd1;
                state_nxt = ST_OUT;
              end else begin
                // Start at the newest entry.
                rd_addr     = IDX_W'(count_dec);
                chk_idx_nxt = IDX_W'(count_dec);
                state_nxt   = ST_SCAN;
              end
            end
            OP_RELEASE: begin
              state_nxt = ST_REL;
            end
            OP_CLEAR: begin
              count_nxt          = '0;
              res_nxt.handle_out = '0;
              res_nxt.outcome    = OC_CLEAR;
              res_nxt.shrunk     = 1'b0;
              res_nxt.pool_count = '0;
              state_nxt          = ST_OUT;
            end
            default: begin
              // Unused code: no result.
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        rd_addr = chk_idx_r - IDX_W'(1);
        if (hit_exact) begin
          // Newest exact match ends the search.
          take_go      = 1'b1;
          take_idx     = chk_idx_r;
          take_handle  = rd_data_r.handle;
          take_outcome = OC_EXACT;
        end else begin
          if (hit_mip && !mip_hit_r) begin
            mip_hit_nxt    = 1'b1;
            mip_idx_nxt    = chk_idx_r;
            mip_handle_nxt = rd_data_r.handle;
          end
          if (chk_idx_r == '0) begin
            if (mip_hit_r) begin
              take_go      = 1'b1;
              take_idx     = mip_idx_r;
              take_handle  = mip_handle_r;
              take_outcome = OC_MIP;
            end else if (hit_mip) begin
              take_go      = 1'b1;
              take_idx     = chk_idx_r;
              take_handle  = rd_data_r.handle;
              take_outcome = OC_MIP;
            end else begin
              res_nxt.handle_out = fresh_r;
              res_nxt.outcome    = OC_FRESH;
              res_nxt.shrunk     = 1'b0;
              res_nxt.pool_count = COUNT_OUT_W'(count_r);
              fresh_nxt = (fresh_r == '1) ? 32'd1 : fresh_r + 32'd1;
              state_nxt = ST_OUT;
            end
          end else begin
            chk_idx_nxt = chk_idx_r - IDX_W'(1);
          end
        end

        if (take_go) begin
          res_nxt.handle_out = take_handle;
          res_nxt.outcome    = take_outcome;
          res_nxt.shrunk     = 1'b0;
          res_nxt.pool_count = COUNT_OUT_W'(count_dec);
          if (CNT_W'(take_idx) == count_dec) begin
            // Newest entry taken: nothing to move.
            count_nxt = count_dec;
            state_nxt = ST_OUT;
          end else begin
            rd_addr   = take_idx + IDX_W'(1);
            src_nxt   = take_idx + IDX_W'(1);
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        // Move the entry read last cycle one place down, read the next one.
        wr_en   = 1'b1;
        wr_addr = src_r - IDX_W'(1);
        wr_data = rd_data_r;
        rd_addr = src_r + IDX_W'(1);
        if (CNT_W'(src_r) == count_dec) begin
          count_nxt = count_dec;
          state_nxt = ST_OUT;
        end else begin
          src_nxt = src_r + IDX_W'(1);
        end
      end

      ST_REL: begin
        res_nxt.handle_out = '0;
        if ((count_r >= CNT_W'(POOL_DEPTH)) || (item_r.handle_in == '0)) begin
          res_nxt.outcome    = OC_DROP;
          res_nxt.shrunk     = 1'b0;
          res_nxt.pool_count = COUNT_OUT_W'(count_r);
        end else begin
          wr_en                 = 1'b1;
          wr_addr               = IDX_W'(count_r);
          wr_data.handle        = item_r.handle_in;
          wr_data.width         = do_shrink ? 13'd1 : item_r.width;
          wr_data.height        = do_shrink ? 13'd1 : item_r.height;
          wr_data.mip_levels    = item_r.mip_levels;
          wr_data.render_target = item_r.render_target;
          count_nxt             = count_r + CNT_W'(1);
          res_nxt.outcome       = OC_RELEASE;
          res_nxt.shrunk        = do_shrink;
          res_nxt.pool_count    = COUNT_OUT_W'(count_r + CNT_W'(1));
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        // Hand the result over once the output register is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      fresh_r     <= 32'd1;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
      mip_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      mip_hit_r   <= mip_hit_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    chk_idx_r    <= chk_idx_nxt;
    src_r        <= src_nxt;
    mip_idx_r    <= mip_idx_nxt;
    mip_handle_r <= mip_handle_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // The pool never holds more entries than the memory has rows.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(POOL_DEPTH))
    else $error("pool count above depth");

  // Zero means no texture and is never handed out fresh.
  a_fresh_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r != '0)
    else $error("fresh handle counter reached zero");

  // A result of a fresh grant carries a nonzero handle.
  a_fresh_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.outcome == OC_FRESH)) |-> (out_data_r.handle_out != '0))
    else $error("fresh grant with zero handle");

  // Finishing a removal shortens the pool by exactly one entry.
  a_shift_count: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SHIFT) && (state_nxt == ST_OUT)) |=> (count_r == $past(count_dec)))
    else $error("removal did not shorten the pool by one");

  // Shifting only happens inside the occupied part of the pool.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT) |-> ((CNT_W'(src_r) < count_r) && (src_r != '0)))
    else $error("shift source outside the pool");

endmodule

/* tb/thrp_pool_monitor.sv */
// ----------------------------------------------------------------------------
// thrp_pool_monitor: prediction and checking for the texture handle pool
// Watches the request, reply and register ports, keeps its own copy of the
// pool, and compares every reply field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module thrp_pool_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  thrp_pkg::thrp_in_t            in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  thrp_pkg::thrp_out_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [thrp_pkg::LIMIT_W-1:0]  cfg_wr_data,
  output int                            fail_count,
  output int                            pending_count
);
  import thrp_pkg::*;

  thrp_entry_t        pool_model[$];
  thrp_out_t          predicted_replies[$];
  logic [31:0]        fresh_handle;
  logic [LIMIT_W-1:0] area_limit;

  // Index of the newest entry that matches the request, or -1.
  function automatic int newest_match(thrp_in_t req, bit size_too);
    for (int i = pool_model.size() - 1; i >= 0; i--) begin
      if (pool_model[i].mip_levels == req.mip_levels &&
          pool_model[i].render_target == req.render_target &&
          (!size_too || (pool_model[i].width == req.width &&
                         pool_model[i].height == req.height)))
        return i;
    end
    return -1;
  endfunction

  function automatic void model_pool_op(thrp_in_t req);
    thrp_out_t         reply;
    thrp_entry_t       ent;
    int                idx;
    logic [AREA_W-1:0] area;
    reply = '0;
    case (req.op)
      OP_ALLOC: begin
        idx = newest_match(req, 1'b1);
        if (idx >= 0) begin
          reply.outcome = OC_EXACT;
        end else begin
          idx = newest_match(req, 1'b0);
          reply.outcome = OC_MIP;
        end
        if (idx >= 0) begin
          reply.handle_out = pool_model[idx].handle;
          pool_model.delete(idx);
        end else begin
          reply.outcome    = OC_FRESH;
          reply.handle_out = fresh_handle;
          fresh_handle     = (fresh_handle == '1) ? 32'd1 : fresh_handle + 32'd1;
        end
      end
      OP_RELEASE: begin
        if (pool_model.size() >= POOL_DEPTH || req.handle_in == '0) begin
          reply.outcome = OC_DROP;
        end else begin
          ent.handle        = req.handle_in;
          ent.width         = req.width;
          ent.height        = req.height;
          ent.mip_levels    = req.mip_levels;
          ent.render_target = req.render_target;
          area = req.width * req.height;
          // Large single-mip textures go back into the pool as 1x1.
          if (area > area_limit && req.mip_levels == 5'd1) begin
            ent.width    = 13'd1;
            ent.height   = 13'd1;
            reply.shrunk = 1'b1;
          end
          pool_model.insert(pool_model.size(), ent);
          reply.outcome = OC_RELEASE;
        end
      end
      OP_CLEAR: begin
        pool_model.delete();
        reply.outcome = OC_CLEAR;
      end
      default: return;
    endcase
    reply.pool_count = COUNT_OUT_W'(pool_model.size());
    predicted_replies.insert(predicted_replies.size(), reply);
  endfunction

  function automatic void compare_reply(thrp_out_t got);
    thrp_out_t want;
    if (predicted_replies.size() == 0) begin
      $display("%0t: unexpected reply %h with no request outstanding", $time, got);
      fail_count++;
      return;
    end
    want = predicted_replies.pop_front();
    if (got.handle_out !== want.handle_out) begin
      $display("%0t: handle_out expected %h actual %h", $time, want.handle_out,
               got.handle_out);
      fail_count++;
    end
    if (got.outcome !== want.outcome) begin
      $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, got.outcome);
      fail_count++;
    end
    if (got.shrunk !== want.shrunk) begin
      $display("%0t: shrunk expected %0d actual %0d", $time, want.shrunk, got.shrunk);
      fail_count++;
    end
    if (got.pool_count !== want.pool_count) begin
      $display("%0t: pool_count expected %0d actual %0d", $time, want.pool_count,
               got.pool_count);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      pool_model.delete();
      predicted_replies.delete();
      fresh_handle = 32'd1;
      area_limit   = LIMIT_RESET;
      fail_count   = 0;
    end else begin
      // A reply at this edge can only belong to an earlier request.
      if (out_valid && !out_stall)
        compare_reply(out_data);
      if (in_valid && !in_stall)
        model_pool_op(in_data);
      if (cfg_wr_en)
        area_limit = cfg_wr_data;
    end
    pending_count = predicted_replies.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the texture handle recycling pool
// Drives directed and random allocate, release and clear requests with random
// gaps and reply stalls, sweeps the small-area limit across its range, and
// reports the verdict from the monitor's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import thrp_pkg::*;

  typedef struct {
    logic [12:0] w;
    logic [12:0] h;
    logic [4:0]  mips;
    logic        rt;
  } tex_shape_t;

  // The slowest allocate scans and shifts the whole pool,
  // so the drain wait before a register write and at the end covers that.
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int PHASE_ITEMS  = 270;
  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 400;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  thrp_in_t           in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  thrp_out_t          out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [LIMIT_W-1:0] cfg_wr_data = '0;

  int  fail_count;
  int  pending_count;
  int  cycle_count   = 0;
  int  hold_requests = 0;
  bit  idling_on     = 1'b1;

  // A small set of texture shapes that requests keep returning to, so that
  // allocations find released entries instead of always taking fresh handles.
  tex_shape_t palette[6];

  always #4 clk = ~clk;

  texture_handle_recycling_pool_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  thrp_pool_monitor u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Offers one item, starting and ending at a falling edge. Valid is only
  // dropped when a gap is drawn, so back-to-back items keep it high.
  task automatic drive_item(input thrp_in_t item);
    int gap;
    gap = idling_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic directed_item(input thrp_op_t op, input int w, input int h,
                               input int mips, input bit rt, input logic [31:0] handle);
    thrp_in_t item;
    item.op            = op;
    item.width         = 13'(w);
    item.height        = 13'(h);
    item.mip_levels    = 5'(mips);
    item.render_target = rt;
    item.handle_in     = handle;
    drive_item(item);
  endtask

  // Most requests reuse a palette shape; some keep only its mip count and
  // render-target flag, and a few are fully random, with mip counts up to 31.
  function automatic thrp_in_t random_request(int rel_pct, int alloc_pct);
    thrp_in_t   req;
    tex_shape_t s;
    int         roll;
    int         pick;
    roll = $urandom_range(0, 99);
    if (roll < rel_pct)
      req.op = OP_RELEASE;
    else if (roll < rel_pct + alloc_pct)
      req.op = OP_ALLOC;
    else if (roll < rel_pct + alloc_pct + 2)
      req.op = OP_CLEAR;
    else
      req.op = OP_NONE;
    s    = palette[$urandom_range(0, 5)];
    pick = $urandom_range(0, 7);
    req.width         = (pick < 5) ? s.w : 13'($urandom);
    req.height        = (pick < 5) ? s.h : 13'($urandom);
    req.mip_levels    = (pick < 7) ? s.mips : 5'($urandom);
    req.render_target = (pick < 7) ? s.rt : 1'($urandom);
    req.handle_in     = ($urandom_range(0, 15) == 0) ? 32'd0 : 32'($urandom);
    return req;
  endfunction

  // Register writes happen only with the block idle: every reply is in, and
  // a request with no reply has had time to finish.
  task automatic write_area_limit(input logic [LIMIT_W-1:0] value);
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Stimulus.
  initial begin
    logic [LIMIT_W-1:0] limits[NUM_PHASES];
    int                 rel_pct;
    for (int k = 0; k < 5; k++) begin
      palette[k].w    = (k < 3) ? 13'($urandom_range(1, 32)) : 13'($urandom);
      palette[k].h    = (k < 3) ? 13'($urandom_range(1, 32)) : 13'($urandom);
      palette[k].mips = (k % 3 == 0) ? 5'd1 : 5'($urandom_range(0, 16));
      palette[k].rt   = 1'($urandom);
    end
    // The shape that a shrunk release turns into.
    palette[5] = '{w: 13'd1, h: 13'd1, mips: 5'd1, rt: 1'b0};

    // Phase 0 runs at the reset value; the rest sweep the limit.
    limits[0] = LIMIT_RESET;
    limits[1] = '0;
    limits[2] = LIMIT_W'(67108864);
    limits[3] = '1;
    limits[4] = LIMIT_W'(1);
    limits[5] = LIMIT_W'($urandom_range(0, 67108864));
    limits[6] = LIMIT_RESET;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset limit of 4096.
    directed_item(OP_ALLOC,   0,    0,    0,  1'b0, 32'h0);        // fresh from empty pool
    directed_item(OP_RELEASE, 5,    5,    3,  1'b0, 32'h0);        // handle zero is dropped
    directed_item(OP_RELEASE, 64,   64,   1,  1'b0, 32'h101);      // area equal to limit
    directed_item(OP_RELEASE, 64,   65,   1,  1'b0, 32'h102);      // just above: shrunk
    directed_item(OP_RELEASE, 8191, 8191, 16, 1'b1, 32'hFFFFFFFF); // many mips, not shrunk
    directed_item(OP_RELEASE, 100,  100,  2,  1'b0, 32'h103);
    directed_item(OP_RELEASE, 200,  50,   2,  1'b0, 32'h104);
    directed_item(OP_ALLOC,   100,  100,  2,  1'b0, 32'hFFFFFFFF); // exact beats newer mip match
    directed_item(OP_ALLOC,   7,    7,    2,  1'b0, 32'h0);        // mip-only reuse
    directed_item(OP_ALLOC,   64,   64,   1,  1'b0, 32'h0);        // exact
    directed_item(OP_ALLOC,   1,    1,    1,  1'b0, 32'h0);        // finds the shrunk entry
    directed_item(OP_ALLOC,   8191, 8191, 16, 1'b0, 32'h0);        // flag differs: fresh
    directed_item(OP_ALLOC,   8191, 8191, 16, 1'b1, 32'h0);        // exact
    directed_item(OP_RELEASE, 8191, 0,    31, 1'b1, 32'h80000000);
    directed_item(OP_RELEASE, 8191, 0,    31, 1'b1, 32'h105);
    directed_item(OP_ALLOC,   8191, 0,    31, 1'b1, 32'h0);        // newest of two equals
    directed_item(OP_NONE,    8191, 8191, 31, 1'b1, 32'hFFFFFFFF); // unused code, no reply
    directed_item(OP_RELEASE, 3,    3,    0,  1'b0, 32'h106);
    directed_item(OP_CLEAR,   8191, 8191, 31, 1'b1, 32'hFFFFFFFF);
    directed_item(OP_ALLOC,   3,    3,    0,  1'b0, 32'h0);        // pool was cleared: fresh

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        write_area_limit(limits[p]);
      end
      // Phase 1 is release-heavy so the pool fills and releases get dropped.
      rel_pct = (p == 1) ? 85 : 48;
      // Phase 4 runs without gaps on either side.
      idling_on = (p != 4);
      // In phase 2 the reply side holds off long enough to back up the input.
      if (p == 2)
        hold_requests++;
      repeat (PHASE_ITEMS) drive_item(random_request(rel_pct, 96 - rel_pct));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Reply side: unless gaps are off, stalls for a random number of cycles before
  // each item, or for one long stretch when the stimulus asks for back-pressure.
  initial begin
    int stall_cycles;
    int holds_done;
    holds_done = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_requests > holds_done) begin
        holds_done++;
        stall_cycles = HOLD_CYCLES;
      end else begin
        stall_cycles = idling_on ? $urandom_range(0, 12) : 0;
      end
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
